// ===== src/lsal_pkg.sv =====
// ----------------------------------------------------------------------------
// lsal_pkg
// Shared types, constants and helpers for the light sensor auto-gain and
// lux block.
// ----------------------------------------------------------------------------
package lsal_pkg;

  // Raw count limits for the gain decision
  localparam logic [15:0] SAT_LEVEL = 16'hFFFF;
  localparam logic [15:0] HI_LIMIT  = 16'(65535 / 30);
  localparam logic [15:0] MID_LIMIT = 16'(65535 / 450);
  localparam logic [15:0] LOW_LIMIT = 16'(65535 / 10000);

  // Gain steps
  localparam logic [1:0] GAIN_LOW  = 2'd0;
  localparam logic [1:0] GAIN_MED  = 2'd1;
  localparam logic [1:0] GAIN_HIGH = 2'd2;
  localparam logic [1:0] GAIN_MAX  = 2'd3;

  // Read counter
  localparam logic [2:0] TRY_FIRST = 3'd1;
  localparam logic [2:0] TRY_MAX   = 3'd7;

  // Lux coefficient and widths of the fixed-point datapath
  localparam logic [8:0] LUX_COEF = 9'd408;
  localparam int unsigned NUM_W   = 41;  // 408 * d^2 < 2^41
  localparam int unsigned DEN_W   = 40;  // c0 * 600 * 9876 < 2^40
  localparam int unsigned MS_W    = 10;
  localparam int unsigned SCALE_W = 14;

  // Integration register
  localparam logic [2:0] STEPS_RESET = 3'd1;
  localparam logic [2:0] STEPS_MIN   = 3'd1;
  localparam logic [2:0] STEPS_MAX   = 3'd6;

  // Relative gain of each step
  localparam logic [SCALE_W-1:0] GAIN_SCALE [4] = '{
    14'd1, 14'd25, 14'd428, 14'd9876
  };

  // Result of the gain decision for one transfer
  typedef struct packed {
    logic       done_res;
    logic       write_gain;
    logic [1:0] gain_to_set;
    logic [1:0] measured_gain;
    logic [2:0] tries;
    logic       lux_start;
    logic       lux_invalid;
  } gain_dec_t;

  // Integration time in ms, register clamped to 1..6
  function automatic logic [MS_W-1:0] ms_of(input logic [2:0] steps);
    logic [2:0] s;
    s = steps;
    if (s < STEPS_MIN) s = STEPS_MIN;
    if (s > STEPS_MAX) s = STEPS_MAX;
    return MS_W'(s) * MS_W'(100);
  endfunction

endpackage

// ===== src/lsal_gain.sv =====
// ----------------------------------------------------------------------------
// lsal_gain
// Auto-gain decision: holds the current gain step and read count, and
// decides per reading pair whether to re-read at a new gain or finish.
// ----------------------------------------------------------------------------
module lsal_gain
  import lsal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [15:0] full_count,
  input  logic [15:0] infrared_count,
  output gain_dec_t   dec
);

  logic [1:0] gain_step_r, gain_step_nxt;
  logic [2:0] try_count_r, try_count_nxt;
  logic       sat;
  logic [2:0] try_bump;

  assign sat      = (full_count == SAT_LEVEL) || (infrared_count == SAT_LEVEL);
  assign try_bump = (try_count_r == TRY_MAX) ? TRY_MAX : try_count_r + 3'd1;

  // Decision
  always_comb begin
    dec           = '0;
    gain_step_nxt = gain_step_r;
    try_count_nxt = try_count_r;
    if (sat && gain_step_r != GAIN_LOW) begin
      // saturated: back off one step
      gain_step_nxt   = gain_step_r - 2'd1;
      try_count_nxt   = try_bump;
      dec.write_gain  = 1'b1;
      dec.gain_to_set = gain_step_r - 2'd1;
    end else if (gain_step_r != GAIN_LOW || full_count > HI_LIMIT ||
                 infrared_count > HI_LIMIT) begin
      // finish, return to gain 0
      dec.done_res      = 1'b1;
      dec.write_gain    = (gain_step_r != GAIN_LOW);
      dec.gain_to_set   = GAIN_LOW;
      dec.measured_gain = gain_step_r;
      dec.tries         = try_count_r;
      dec.lux_invalid   = (full_count == 16'd0);
      dec.lux_start     = (full_count != 16'd0);
      gain_step_nxt     = GAIN_LOW;
      try_count_nxt     = TRY_FIRST;
    end else begin
      // dim at gain 0: pick a higher gain
      if (full_count > MID_LIMIT || infrared_count > MID_LIMIT) begin
        gain_step_nxt = GAIN_MED;
      end else if (full_count > LOW_LIMIT || infrared_count > LOW_LIMIT) begin
        gain_step_nxt = GAIN_HIGH;
      end else begin
        gain_step_nxt = GAIN_MAX;
      end
      try_count_nxt   = try_bump;
      dec.write_gain  = 1'b1;
      dec.gain_to_set = gain_step_nxt;
    end
  end

  // State
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_step_r <= GAIN_LOW;
      try_count_r <= TRY_FIRST;
    end else if (accept) begin
      gain_step_r <= gain_step_nxt;
      try_count_r <= try_count_nxt;
    end
  end

endmodule

// ===== src/lsal_lux.sv =====
// ----------------------------------------------------------------------------
// lsal_lux
// Lux computation: one shared 32x16 multiplier builds numerator and
// denominator in turn, then a restoring divider takes one quotient bit
// per cycle. The quotient saturates at 32 bits.
// ----------------------------------------------------------------------------
module lsal_lux
  import lsal_pkg::*;
#(
  parameter int unsigned LUX_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       full_count,
  input  logic [15:0]       infrared_count,
  input  logic [1:0]        gain,
  input  logic [MS_W-1:0]   ms,
  output logic              busy,
  output logic              done,
  output logic [31:0]       lux
);

  localparam int unsigned NW = NUM_W + LUX_FRAC_BITS;
  localparam int unsigned CW = $clog2(NW);

  // Multiplier operation order
  localparam logic [1:0] MUL_SQ   = 2'd0;
  localparam logic [1:0] MUL_COEF = 2'd1;
  localparam logic [1:0] MUL_MS   = 2'd2;
  localparam logic [1:0] MUL_GAIN = 2'd3;

  typedef enum logic [3:0] {
    LS_IDLE = 4'b0001,
    LS_MUL  = 4'b0010,
    LS_DIV  = 4'b0100,
    LS_DONE = 4'b1000
  } lux_state_t;

  lux_state_t           state_r, state_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [15:0]          d_r, d_nxt;
  logic [15:0]          c0_r, c0_nxt;
  logic [SCALE_W-1:0]   scale_r, scale_nxt;
  logic [MS_W-1:0]      ms_r, ms_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [NW-1:0]        dvd_r, dvd_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [31:0]          quot_r, quot_nxt;
  logic                 ovf_r, ovf_nxt;

  logic [31:0]          mul_a;
  logic [15:0]          mul_b;
  logic [47:0]          prod;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 qbit;

  // Shared multiplier operand select
  always_comb begin
    case (step_r)
      MUL_SQ: begin
        mul_a = 32'(d_r);
        mul_b = d_r;
      end
      MUL_COEF: begin
        mul_a = num_r[31:0];
        mul_b = 16'(LUX_COEF);
      end
      MUL_MS: begin
        mul_a = 32'(c0_r);
        mul_b = 16'(ms_r);
      end
      MUL_GAIN: begin
        mul_a = 32'(den_r[25:0]);
        mul_b = 16'(scale_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 48'(mul_a) * 48'(mul_b);

  // Restoring divide step
  assign rem_sh  = {rem_r, dvd_r[NW-1]};
  assign qbit    = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    d_nxt     = d_r;
    c0_nxt    = c0_r;
    scale_nxt = scale_r;
    ms_nxt    = ms_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      LS_IDLE: begin
        if (start) begin
          d_nxt     = (full_count >= infrared_count) ? full_count - infrared_count
                                                     : infrared_count - full_count;
          c0_nxt    = full_count;
          scale_nxt = GAIN_SCALE[gain];
          ms_nxt    = ms;
          step_nxt  = MUL_SQ;
          state_nxt = LS_MUL;
        end
      end
      LS_MUL: begin
        case (step_r)
          MUL_SQ, MUL_COEF: num_nxt = prod[NUM_W-1:0];
          MUL_MS, MUL_GAIN: den_nxt = prod[DEN_W-1:0];
          default:          num_nxt = num_r;
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == MUL_GAIN) begin
          dvd_nxt   = NW'(num_r) << LUX_FRAC_BITS;
          rem_nxt   = '0;
          quot_nxt  = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = CW'(NW - 1);
          state_nxt = LS_DIV;
        end
      end
      LS_DIV: begin
        rem_nxt  = qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        dvd_nxt  = dvd_r << 1;
        quot_nxt = {quot_r[30:0], qbit};
        ovf_nxt  = ovf_r | quot_r[31];
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = LS_DONE;
        end
      end
      LS_DONE: begin
        state_nxt = LS_IDLE;
      end
      default: begin
        state_nxt = LS_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LS_IDLE;
      step_r  <= MUL_SQ;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    c0_r    <= c0_nxt;
    scale_r <= scale_nxt;
    ms_r    <= ms_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign busy = (state_r != LS_IDLE);
  assign done = (state_r == LS_DONE);
  assign lux  = ovf_r ? 32'hFFFF_FFFF : quot_r;

endmodule

// ===== src/light_sensor_autogain_lux.sv =====
// Latency: re-read or zero-full-count finish, in the cycle after the input transfer;
//   finish with lux, after the multiply, divide and done states of the lux unit,
//   through the 4-step shared multiply and the one-bit-per-cycle divider.
// Throughput: one pair at a time, next input once the result is taken.
// Reset (rst_n low, synchronous): gain 0, read count 1, integration 1.
// ----------------------------------------------------------------------------
// light_sensor_autogain_lux
// Ambient light auto-gain and lux calculation: gain decision per reading
// pair and a serial fixed-point lux computation.
// ----------------------------------------------------------------------------
module light_sensor_autogain_lux
  import lsal_pkg::*;
#(
  parameter int unsigned LUX_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_full_count,
  input  logic [15:0] in_infrared_count,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_done_res,
  output logic        out_write_gain,
  output logic [1:0]  out_gain_to_set,
  output logic [1:0]  out_measured_gain,
  output logic [2:0]  out_tries,
  output logic [31:0] out_lux_q8,
  output logic        out_lux_invalid
);

  logic [2:0]  steps_r;
  logic        out_valid_r, out_valid_nxt;
  logic        wait_lux_r, wait_lux_nxt;
  gain_dec_t   dec;
  gain_dec_t   dec_r;
  logic [31:0] lux_r;
  logic        accept;
  logic        lux_busy;
  logic        lux_done;
  logic [31:0] lux_val;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r && !wait_lux_r && !lux_busy;

  // Integration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= STEPS_RESET;
    end else if (cfg_wr_en) begin
      steps_r <= cfg_wr_data;
    end
  end

  lsal_gain u_gain (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .full_count     (in_full_count),
    .infrared_count (in_infrared_count),
    .dec            (dec)
  );

  lsal_lux #(
    .LUX_FRAC_BITS (LUX_FRAC_BITS)
  ) u_lux (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (accept && dec.lux_start),
    .full_count     (in_full_count),
    .infrared_count (in_infrared_count),
    .gain           (dec.measured_gain),
    .ms             (ms_of(steps_r)),
    .busy           (lux_busy),
    .done           (lux_done),
    .lux            (lux_val)
  );

  // Output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    wait_lux_nxt  = wait_lux_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      if (dec.lux_start) begin
        wait_lux_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end
    if (wait_lux_r && lux_done) begin
      wait_lux_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wait_lux_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      wait_lux_r  <= wait_lux_nxt;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      dec_r <= dec;
      lux_r <= '0;
    end else if (wait_lux_r && lux_done) begin
      lux_r <= lux_val;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_done_res      = dec_r.done_res;
  assign out_write_gain    = dec_r.write_gain;
  assign out_gain_to_set   = dec_r.gain_to_set;
  assign out_measured_gain = dec_r.measured_gain;
  assign out_tries         = dec_r.tries;
  assign out_lux_q8        = lux_r;
  assign out_lux_invalid   = dec_r.lux_invalid;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the light sensor auto-gain and lux block. A queue
// of reading pairs feeds a valid/ready driver; a monitor predicts the gain
// decision and fixed-point lux for every input transfer and compares each
// result transfer, field by field, in order. Directed corner cases come
// first, then random phases over all integration settings, with random
// idling on both sides, one long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module testbench;
  import lsal_pkg::*;

  localparam int unsigned LUX_FRAC       = 8;
  localparam int unsigned ITEMS_PER_HALF = 100;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned END_SETTLE     = 60;

  typedef struct packed {
    logic [15:0] full_count;
    logic [15:0] infrared_count;
  } reading_t;

  typedef struct packed {
    logic        done_res;
    logic        write_gain;
    logic [1:0]  gain_to_set;
    logic [1:0]  measured_gain;
    logic [2:0]  tries;
    logic [31:0] lux_q8;
    logic        lux_invalid;
  } lux_result_t;

  // DUT connections, inputs known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_full_count = '0;
  logic [15:0] in_infrared_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_done_res;
  logic        out_write_gain;
  logic [1:0]  out_gain_to_set;
  logic [1:0]  out_measured_gain;
  logic [2:0]  out_tries;
  logic [31:0] out_lux_q8;
  logic        out_lux_invalid;

  // Stimulus and scoreboard
  reading_t    pending_readings [$];
  lux_result_t expected_results [$];
  int unsigned failures = 0;
  int unsigned in_offered = 0;
  int unsigned in_accepted = 0;
  int unsigned out_accepted = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;
  int unsigned hold_requests = 0;

  // Predictor state
  logic [1:0]  gain_step = GAIN_LOW;
  logic [2:0]  try_count = TRY_FIRST;
  logic [2:0]  steps_reg = STEPS_RESET;

  light_sensor_autogain_lux #(
    .LUX_FRAC_BITS(LUX_FRAC)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_full_count     (in_full_count),
    .in_infrared_count (in_infrared_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_done_res      (out_done_res),
    .out_write_gain    (out_write_gain),
    .out_gain_to_set   (out_gain_to_set),
    .out_measured_gain (out_measured_gain),
    .out_tries         (out_tries),
    .out_lux_q8        (out_lux_q8),
    .out_lux_invalid   (out_lux_invalid)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gain decision and lux for one reading pair; advances the predictor state
  task automatic predict_reading(input logic [15:0] c0, input logic [15:0] c1,
                                 output lux_result_t r);
    logic [1:0]  g;
    logic [2:0]  steps;
    logic [15:0] d;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    r = '0;
    g = gain_step;
    if ((c0 == SAT_LEVEL || c1 == SAT_LEVEL) && g != GAIN_LOW) begin
      // saturated: one step down, read again
      g = g - 2'd1;
      gain_step = g;
      if (try_count < TRY_MAX) try_count = try_count + 3'd1;
      r.write_gain  = 1'b1;
      r.gain_to_set = g;
    end else if (g != GAIN_LOW || c0 > HI_LIMIT || c1 > HI_LIMIT) begin
      // finish at the current gain, then back to gain 0
      r.done_res      = 1'b1;
      r.write_gain    = (g != GAIN_LOW);
      r.measured_gain = g;
      r.tries         = try_count;
      if (c0 == '0) begin
        r.lux_invalid = 1'b1;
      end else begin
        steps = steps_reg;
        if (steps < STEPS_MIN) steps = STEPS_MIN;
        if (steps > STEPS_MAX) steps = STEPS_MAX;
        d   = (c0 >= c1) ? (c0 - c1) : (c1 - c0);
        num = (64'(LUX_COEF) * 64'(d) * 64'(d)) << LUX_FRAC;
        den = 64'(c0) * 64'(steps) * 64'd100 * 64'(GAIN_SCALE[g]);
        q   = num / den;
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        r.lux_q8 = q[31:0];
      end
      gain_step = GAIN_LOW;
      try_count = TRY_FIRST;
    end else begin
      // dim at gain 0: pick a higher gain, read again
      if (c0 > MID_LIMIT || c1 > MID_LIMIT) g = GAIN_MED;
      else if (c0 > LOW_LIMIT || c1 > LOW_LIMIT) g = GAIN_HIGH;
      else g = GAIN_MAX;
      gain_step = g;
      if (try_count < TRY_MAX) try_count = try_count + 3'd1;
      r.write_gain  = 1'b1;
      r.gain_to_set = g;
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      failures++;
    end
  endfunction

  // Monitor: both channels sampled at the rising edge, plus watchdog
  lux_result_t predicted;
  lux_result_t oldest;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_accepted++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result pending");
          failures++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("done_res", 32'(oldest.done_res), 32'(out_done_res));
          check_field("write_gain", 32'(oldest.write_gain), 32'(out_write_gain));
          check_field("gain_to_set", 32'(oldest.gain_to_set), 32'(out_gain_to_set));
          check_field("measured_gain", 32'(oldest.measured_gain), 32'(out_measured_gain));
          check_field("tries", 32'(oldest.tries), 32'(out_tries));
          check_field("lux_q8", oldest.lux_q8, out_lux_q8);
          check_field("lux_invalid", 32'(oldest.lux_invalid), 32'(out_lux_invalid));
        end
      end
      if (in_valid && in_ready) begin
        in_accepted++;
        predict_reading(in_full_count, in_infrared_count, predicted);
        expected_results.push_back(predicted);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Driver: one pending reading per transfer, random gap between items
  bit          next_valid;
  int unsigned in_gap = 0;
  reading_t    cur_reading;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid && (in_accepted != in_offered);
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_readings.size() > 0) begin
          cur_reading = pending_readings.pop_front();
          in_full_count     <= cur_reading.full_count;
          in_infrared_count <= cur_reading.infrared_count;
          in_offered++;
          next_valid = 1'b1;
          in_gap = no_idle ? 0 : $urandom_range(5, 0);
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: random stall per result, one long hold-off on request
  int unsigned out_seen = 0;
  int unsigned out_wait = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (out_seen != out_accepted) begin
        out_seen = out_accepted;
        out_wait = no_idle ? 0 : $urandom_range(5, 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_valid && out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_reading(input logic [15:0] c0, input logic [15:0] c1);
    reading_t r;
    r.full_count     = c0;
    r.infrared_count = c1;
    pending_readings.push_back(r);
  endtask

  // Reading pair drawn from a band of the gain decision
  function automatic reading_t random_reading();
    reading_t    r;
    logic [15:0] t;
    int unsigned band;
    band = $urandom_range(99, 0);
    r.full_count     = 16'($urandom_range(65535, 0));
    r.infrared_count = 16'($urandom_range(65535, 0));
    if (band < 25) begin
      // saturated channel(s)
      case ($urandom_range(2, 0))
        0:       r.full_count = SAT_LEVEL;
        1:       r.infrared_count = SAT_LEVEL;
        default: begin
          r.full_count     = SAT_LEVEL;
          r.infrared_count = SAT_LEVEL;
        end
      endcase
    end else if (band < 40) begin
      r.full_count = 16'($urandom_range(SAT_LEVEL - 1, HI_LIMIT + 1));
    end else if (band < 55) begin
      r.full_count     = 16'($urandom_range(HI_LIMIT, 0));
      r.infrared_count = 16'($urandom_range(HI_LIMIT, MID_LIMIT + 1));
    end else if (band < 67) begin
      r.full_count     = 16'($urandom_range(MID_LIMIT, 0));
      r.infrared_count = 16'($urandom_range(MID_LIMIT, LOW_LIMIT + 1));
    end else if (band < 80) begin
      r.full_count     = 16'($urandom_range(LOW_LIMIT, 0));
      r.infrared_count = 16'($urandom_range(LOW_LIMIT, 0));
    end else if (band < 85) begin
      // zero full count, infrared anywhere
      r.full_count = '0;
      if ($urandom_range(1, 0)) r.infrared_count = 16'($urandom_range(HI_LIMIT, 0));
    end
    // bands above are built with infrared in the upper range; swap half of them
    if (band >= 40 && band < 80 && $urandom_range(1, 0)) begin
      t                = r.full_count;
      r.full_count     = r.infrared_count;
      r.infrared_count = t;
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_readings.size() != 0 || in_accepted != in_offered ||
           expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_steps(input logic [2:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    steps_reg = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sequencer
  logic [2:0] phase_steps [9] = '{3'd6, 3'd0, 3'd7, 3'd2, 3'd1, 3'd3, 3'd4, 3'd5, 3'd6};
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_steps(STEPS_MIN);

    // Directed: every band of the decision, zero full count, lux saturation
    push_reading(16'd0, 16'd0);                  // tiny -> max gain
    push_reading(16'd0, 16'd0);                  // finish at max gain, invalid
    push_reading(HI_LIMIT + 16'd1, 16'd0);       // finish at gain 0, no gain write
    push_reading(HI_LIMIT, HI_LIMIT);            // -> medium gain
    push_reading(SAT_LEVEL, 16'd0);              // saturated -> step down
    push_reading(SAT_LEVEL, SAT_LEVEL);          // finish at gain 0, zero lux
    push_reading(MID_LIMIT, MID_LIMIT + 16'd1);  // -> medium gain
    push_reading(16'd40000, 16'd1);              // finish at medium gain
    push_reading(MID_LIMIT, LOW_LIMIT + 16'd1);  // -> high gain
    push_reading(16'd1, 16'd0);                  // finish at high gain
    push_reading(LOW_LIMIT, LOW_LIMIT);          // -> max gain
    push_reading(16'd65534, 16'd0);              // finish at max gain
    push_reading(16'd1, SAT_LEVEL);              // lux saturates
    push_reading(16'd0, SAT_LEVEL);              // invalid at gain 0
    // gain hunting long enough for the read count to saturate
    push_reading(16'd0, 16'd0);
    push_reading(SAT_LEVEL, 16'd0);
    push_reading(16'd0, SAT_LEVEL);
    push_reading(SAT_LEVEL, SAT_LEVEL);
    push_reading(16'd0, 16'd0);
    push_reading(SAT_LEVEL, 16'd3);
    push_reading(SAT_LEVEL, 16'd100);
    push_reading(16'd5, SAT_LEVEL);
    push_reading(16'd50000, 16'd100);            // finish with read count at max
    wait_drained();

    // Random phases over the integration settings, out-of-range ones included
    foreach (phase_steps[p]) begin
      repeat (4) @(negedge clk);
      no_idle = (p % 4 == 3);
      write_steps(phase_steps[p]);
      repeat (ITEMS_PER_HALF) pending_readings.push_back(random_reading());
      if (p == 2) hold_requests++;
      wait_drained();
      repeat (ITEMS_PER_HALF) pending_readings.push_back(random_reading());
      wait_drained();
    end

    repeat (END_SETTLE) @(negedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== light_sensor_autogain_lux.f =====
src/lsal_pkg.sv
src/lsal_gain.sv
src/lsal_lux.sv
src/light_sensor_autogain_lux.sv
test/testbench.sv
